// ===== sv/lrs_pkg.sv =====
// ----------------------------------------------------------------------------
// lrs_pkg
// Shared types and constants for the stereo linear resampler: field widths,
// register indexes, controller commands and datapath status.
// ----------------------------------------------------------------------------
package lrs_pkg;

	// field and state widths
	localparam int SAMPLE_W  = 16;
	localparam int STEP_W    = 34;
	localparam int PHASE_W   = 35;
	localparam int CFG_IDX_W = 2;
	localparam int CFG_W     = STEP_W;

	// most output pairs per source frame
	localparam int MAX_PAIRS = 7;
	localparam int CNT_W     = 3;

	// register indexes
	localparam logic [CFG_IDX_W-1:0] REG_STEP_SIZE   = 2'd0;
	localparam logic [CFG_IDX_W-1:0] REG_MONO_SOURCE = 2'd1;

	// clamp limits
	localparam logic signed [SAMPLE_W-1:0] SAT_MAX = 16'sh7FFF;
	localparam logic signed [SAMPLE_W-1:0] SAT_MIN = -16'sh8000;

	// commands from controller to datapath
	typedef struct packed {
		logic load_cur;    // frame opens a run of pairs
		logic skip_frame;  // frame only updates history and phase
		logic mul_step;    // multiply stage and phase advance
		logic emit;        // load output register
	} lrs_cmd_t;

	// status from datapath to controller
	typedef struct packed {
		logic primed;
		logic phase_ge_one;
		logic last_pair;
	} lrs_stat_t;

	// clamp an 18-bit interpolation result to 16 bits
	function automatic logic signed [SAMPLE_W-1:0] sat16(input logic signed [SAMPLE_W+1:0] v);
		logic signed [SAMPLE_W-1:0] r;
		if (v > 18'(SAT_MAX))
			r = SAT_MAX;
		else if (v < 18'(SAT_MIN))
			r = SAT_MIN;
		else
			r = v[SAMPLE_W-1:0];
		return r;
	endfunction

endpackage

// ===== sv/linear_resampler_stereo.sv =====
// ----------------------------------------------------------------------------
// linear_resampler_stereo
// Linear interpolation resampler to 48 kHz stereo with a 3.32 phase
// accumulator, rounding toward minus infinity and 16-bit clamping.
//
//   channel | signals                                  | direction
//   --------+------------------------------------------+----------
//   input   | in_valid, in_ready, left_in, right_in    | in
//   output  | out_valid, out_ready, left_out,          | out
//           | right_out, run_last                      |
//   config  | cfg_we, cfg_index, cfg_data              | in
//
// A frame that emits pairs, up to seven, then holds the input while each
// pair takes a multiply step and then an output load step through a single
// multiplier per channel. Frames that emit nothing are taken every cycle.
// Reset clears the phase, history and config to their defaults at once.
// An output stall holds the controller in its output step; the next frame
// is taken once the last pair of the current one sits in the output register.
// ----------------------------------------------------------------------------
module linear_resampler_stereo #(
	parameter int FRAC_BITS = 32
) (
	input  logic                                 clk,
	input  logic                                 arst_n,
	input  logic                                 cfg_we,
	input  logic [lrs_pkg::CFG_IDX_W-1:0]        cfg_index,
	input  logic [lrs_pkg::CFG_W-1:0]            cfg_data,
	input  logic                                 in_valid,
	output logic                                 in_ready,
	input  logic signed [lrs_pkg::SAMPLE_W-1:0]  left_in,
	input  logic signed [lrs_pkg::SAMPLE_W-1:0]  right_in,
	output logic                                 out_valid,
	input  logic                                 out_ready,
	output logic signed [lrs_pkg::SAMPLE_W-1:0]  left_out,
	output logic signed [lrs_pkg::SAMPLE_W-1:0]  right_out,
	output logic                                 run_last
);
	import lrs_pkg::*;

	lrs_cmd_t  cmd;
	lrs_stat_t stat;

	// sequencing
	lrs_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (in_valid),
		.in_ready  (in_ready),
		.out_valid (out_valid),
		.out_ready (out_ready),
		.stat      (stat),
		.cmd       (cmd)
	);

	// arithmetic and state
	lrs_datapath #(
		.FRAC_BITS (FRAC_BITS)
	) u_datapath (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_we    (cfg_we),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data),
		.left_in   (left_in),
		.right_in  (right_in),
		.cmd       (cmd),
		.stat      (stat),
		.left_out  (left_out),
		.right_out (right_out),
		.run_last  (run_last)
	);

endmodule

// ===== sv/lrs_datapath.sv =====
// ----------------------------------------------------------------------------
// lrs_datapath
// Configuration registers, phase accumulator, sample history, the two
// interpolation multipliers and the output register.
// ----------------------------------------------------------------------------
module lrs_datapath #(
	parameter int FRAC_BITS = 32
) (
	input  logic                                 clk,
	input  logic                                 arst_n,
	input  logic                                 cfg_we,
	input  logic [lrs_pkg::CFG_IDX_W-1:0]        cfg_index,
	input  logic [lrs_pkg::CFG_W-1:0]            cfg_data,
	input  logic signed [lrs_pkg::SAMPLE_W-1:0]  left_in,
	input  logic signed [lrs_pkg::SAMPLE_W-1:0]  right_in,
	input  lrs_pkg::lrs_cmd_t                    cmd,
	output lrs_pkg::lrs_stat_t                   stat,
	output logic signed [lrs_pkg::SAMPLE_W-1:0]  left_out,
	output logic signed [lrs_pkg::SAMPLE_W-1:0]  right_out,
	output logic                                 run_last
);
	import lrs_pkg::*;

	localparam int PW = SAMPLE_W + 2 + FRAC_BITS;
	localparam logic [PHASE_W-1:0] ONE_PHASE = {{(PHASE_W-1){1'b0}}, 1'b1} << FRAC_BITS;
	localparam logic [STEP_W-1:0]  STEP_RST  = {{(STEP_W-1){1'b0}}, 1'b1} << FRAC_BITS;

	logic [STEP_W-1:0]            step_q;
	logic                         mono_q;
	logic [PHASE_W-1:0]           phase_q;
	logic                         primed_q;
	logic [CNT_W-1:0]             cnt_q;
	logic signed [SAMPLE_W-1:0]   prev_l_q, prev_r_q, cur_l_q, cur_r_q;
	logic signed [PW-1:0]         prod_l_s1, prod_r_s1;
	logic signed [SAMPLE_W-1:0]   left_out_q, right_out_q;
	logic                         run_last_q;

	logic                         step_chg, mono_chg, cfg_chg;
	logic [STEP_W-1:0]            step_wr;
	logic signed [SAMPLE_W-1:0]   in_r_sel;
	logic signed [SAMPLE_W:0]     diff_l, diff_r;
	logic signed [FRAC_BITS:0]    frac;
	logic signed [SAMPLE_W+1:0]   sum_l, sum_r;

	// config writes that change a value restart the history
	assign step_wr  = cfg_data[STEP_W-1:0];
	assign step_chg = cfg_we && (cfg_index == REG_STEP_SIZE) && (step_wr != step_q);
	assign mono_chg = cfg_we && (cfg_index == REG_MONO_SOURCE) && (cfg_data[0] != mono_q);
	assign cfg_chg  = step_chg || mono_chg;

	// status toward controller
	assign stat.primed       = primed_q;
	assign stat.phase_ge_one = |phase_q[PHASE_W-1:FRAC_BITS];
	assign stat.last_pair    = (|phase_q[PHASE_W-1:FRAC_BITS]) || (cnt_q == CNT_W'(MAX_PAIRS));

	// configuration registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			step_q <= STEP_RST;
			mono_q <= 1'b0;
		end else begin
			if (step_chg)
				step_q <= step_wr;
			if (mono_chg)
				mono_q <= cfg_data[0];
		end
	end

	// phase accumulator and history flag
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q  <= '0;
			primed_q <= 1'b0;
		end else begin
			if (cfg_chg) begin
				phase_q  <= '0;
				primed_q <= 1'b0;
			end else if (cmd.skip_frame) begin
				primed_q <= 1'b1;
				if (primed_q)
					phase_q <= phase_q - ONE_PHASE;
			end else if (cmd.mul_step) begin
				phase_q <= phase_q + PHASE_W'(step_q);
			end else if (cmd.emit && stat.last_pair) begin
				phase_q <= stat.phase_ge_one ? (phase_q - ONE_PHASE) : '0;
			end
		end
	end

	// pair counter within a frame
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			cnt_q <= '0;
		else if (cmd.load_cur)
			cnt_q <= '0;
		else if (cmd.mul_step)
			cnt_q <= cnt_q + CNT_W'(1);
	end

	// sample history
	assign in_r_sel = mono_q ? left_in : right_in;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			prev_l_q <= '0;
			prev_r_q <= '0;
			cur_l_q  <= '0;
			cur_r_q  <= '0;
		end else begin
			if (cmd.load_cur) begin
				cur_l_q <= left_in;
				cur_r_q <= in_r_sel;
			end
			if (cmd.skip_frame) begin
				prev_l_q <= left_in;
				prev_r_q <= in_r_sel;
			end else if (cmd.emit && stat.last_pair) begin
				prev_l_q <= cur_l_q;
				prev_r_q <= cur_r_q;
			end
		end
	end

	// multiply stage: slope times fractional phase
	assign diff_l = (SAMPLE_W+1)'(cur_l_q) - (SAMPLE_W+1)'(prev_l_q);
	assign diff_r = (SAMPLE_W+1)'(cur_r_q) - (SAMPLE_W+1)'(prev_r_q);
	assign frac   = $signed({1'b0, phase_q[FRAC_BITS-1:0]});

	always_ff @(posedge clk) begin
		if (cmd.mul_step) begin
			prod_l_s1 <= PW'(diff_l) * PW'(frac);
			prod_r_s1 <= PW'(diff_r) * PW'(frac);
		end
	end

	// floor via arithmetic shift, then add base sample and clamp
	assign sum_l = (SAMPLE_W+2)'(prev_l_q) + prod_l_s1[FRAC_BITS+SAMPLE_W+1:FRAC_BITS];
	assign sum_r = (SAMPLE_W+2)'(prev_r_q) + prod_r_s1[FRAC_BITS+SAMPLE_W+1:FRAC_BITS];

	// output register
	always_ff @(posedge clk) begin
		if (cmd.emit) begin
			left_out_q  <= sat16(sum_l);
			right_out_q <= sat16(sum_r);
			run_last_q  <= stat.last_pair;
		end
	end

	assign left_out  = left_out_q;
	assign right_out = right_out_q;
	assign run_last  = run_last_q;

endmodule

// ===== sv/lrs_ctrl.sv =====
// ----------------------------------------------------------------------------
// lrs_ctrl
// Controller for the resampler: accepts frames, sequences the multiply and
// output steps of each pair and owns the output valid flag.
// ----------------------------------------------------------------------------
module lrs_ctrl (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                in_valid,
	output logic                in_ready,
	output logic                out_valid,
	input  logic                out_ready,
	input  lrs_pkg::lrs_stat_t  stat,
	output lrs_pkg::lrs_cmd_t   cmd
);
	import lrs_pkg::*;

	typedef enum logic [2:0] {
		S_IDLE = 3'b001,
		S_MUL  = 3'b010,
		S_EMIT = 3'b100
	} state_t;

	state_t state_q, state_d;
	logic   out_valid_q;
	logic   in_fire, emit_fire;

	assign in_ready  = (state_q == S_IDLE);
	assign in_fire   = in_valid && in_ready;
	assign emit_fire = (state_q == S_EMIT) && (!out_valid_q || out_ready);

	// command decode
	assign cmd.skip_frame = in_fire && (!stat.primed || stat.phase_ge_one);
	assign cmd.load_cur   = in_fire && stat.primed && !stat.phase_ge_one;
	assign cmd.mul_step   = (state_q == S_MUL);
	assign cmd.emit       = emit_fire;

	// next state
	always_comb begin
		state_d = state_q;
		unique case (state_q)
			S_IDLE: if (cmd.load_cur) state_d = S_MUL;
			S_MUL:  state_d = S_EMIT;
			S_EMIT: if (emit_fire) state_d = stat.last_pair ? S_IDLE : S_MUL;
			default: state_d = S_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			state_q <= S_IDLE;
		else
			state_q <= state_d;
	end

	// output valid flag
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			out_valid_q <= 1'b0;
		else if (emit_fire)
			out_valid_q <= 1'b1;
		else if (out_ready)
			out_valid_q <= 1'b0;
	end

	assign out_valid = out_valid_q;

`ifndef NO_ASSERTIONS
	// a pair is only computed while the phase is inside the interval
	a_mul_in_range: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == S_MUL) |-> !stat.phase_ge_one)
		else $error("multiply step with phase beyond interval");

	// a run of pairs needs valid history
	a_load_needs_prev: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.load_cur |-> stat.primed)
		else $error("run started without history");

	// the output step always follows a multiply step or a stalled output step
	a_emit_after_mul: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == S_EMIT) |-> ($past(state_q) == S_MUL || $past(state_q) == S_EMIT))
		else $error("output step without a product");

	// the last pair of a frame returns to idle and shows out_valid
	a_last_to_idle: assert property (@(posedge clk) disable iff (!arst_n)
		(emit_fire && stat.last_pair) |=> (state_q == S_IDLE && out_valid_q))
		else $error("frame did not close after last pair");
`endif

endmodule

// ===== tb/sv/lrs_pair_checker.sv =====
// ----------------------------------------------------------------------------
// lrs_pair_checker
// Watches the frame, pair and register ports of the stereo resampler. Keeps
// its own phase accumulator and sample history, works out the output pairs
// of every accepted frame and compares each accepted pair with the oldest one
// still due. Hands the mismatch count and the pairs still due to the bench.
// ----------------------------------------------------------------------------
module lrs_pair_checker #(
	parameter int FRAC_BITS = 32
) (
	input  logic                                 clk,
	input  logic                                 arst_n,
	input  logic                                 cfg_we,
	input  logic [lrs_pkg::CFG_IDX_W-1:0]        cfg_index,
	input  logic [lrs_pkg::CFG_W-1:0]            cfg_data,
	input  logic                                 in_valid,
	input  logic                                 in_ready,
	input  logic signed [lrs_pkg::SAMPLE_W-1:0]  left_in,
	input  logic signed [lrs_pkg::SAMPLE_W-1:0]  right_in,
	input  logic                                 out_valid,
	input  logic                                 out_ready,
	input  logic signed [lrs_pkg::SAMPLE_W-1:0]  left_out,
	input  logic signed [lrs_pkg::SAMPLE_W-1:0]  right_out,
	input  logic                                 run_last,
	output int                                   mismatches,
	output int                                   pairs_left
);
	import lrs_pkg::*;

	// one source interval in phase units
	localparam logic [PHASE_W-1:0] ONE_PHASE = {{(PHASE_W-1){1'b0}}, 1'b1} << FRAC_BITS;

	typedef struct packed {
		logic signed [SAMPLE_W-1:0] l_smp;
		logic signed [SAMPLE_W-1:0] r_smp;
		logic                       last;
	} pair_t;

	// shadow of the block's registers and state
	logic [STEP_W-1:0]          step_reg;
	logic                       mono_reg;
	logic [PHASE_W-1:0]         phase;
	logic signed [SAMPLE_W-1:0] prev_l;
	logic signed [SAMPLE_W-1:0] prev_r;
	logic                       primed;

	pair_t pairs_due[$];

	// floor of the weighted sum, worked on offset-binary samples
	function automatic logic signed [SAMPLE_W-1:0] interp(
		input logic signed [SAMPLE_W-1:0] a,
		input logic signed [SAMPLE_W-1:0] b,
		input logic [PHASE_W-1:0]         f
	);
		logic [63:0] ua;
		logic [63:0] ub;
		logic [63:0] sum;
		ua  = {48'd0, a ^ 16'h8000};
		ub  = {48'd0, b ^ 16'h8000};
		sum = ua * (64'(ONE_PHASE) - 64'(f)) + ub * 64'(f);
		sum = sum >> FRAC_BITS;
		// back to two's complement; the blend never leaves the 16-bit range
		return sum[SAMPLE_W-1:0] ^ 16'h8000;
	endfunction

	// pairs caused by one frame, queued in order
	task automatic predict_frame(
		input logic signed [SAMPLE_W-1:0] l_in,
		input logic signed [SAMPLE_W-1:0] r_in
	);
		logic signed [SAMPLE_W-1:0] cur_l;
		logic signed [SAMPLE_W-1:0] cur_r;
		logic [PHASE_W-1:0]         f;
		pair_t                      run [MAX_PAIRS];
		int                         n;
		cur_l = l_in;
		cur_r = mono_reg ? l_in : r_in;
		n = 0;
		if (primed) begin
			while (phase < ONE_PHASE && n < MAX_PAIRS) begin
				f = phase & (ONE_PHASE - 1'b1);
				run[n].l_smp = interp(prev_l, cur_l, f);
				run[n].r_smp = interp(prev_r, cur_r, f);
				run[n].last  = 1'b0;
				n++;
				phase = phase + PHASE_W'(step_reg);
			end
			if (n > 0)
				run[n-1].last = 1'b1;
			for (int i = 0; i < n; i++)
				pairs_due.push_back(run[i]);
			// move down one interval, or drop what is left of a crowded one
			if (phase >= ONE_PHASE)
				phase = phase - ONE_PHASE;
			else
				phase = '0;
		end
		prev_l = cur_l;
		prev_r = cur_r;
		primed = 1'b1;
	endtask

	// register writes, frame predictions and pair compares
	always @(posedge clk or negedge arst_n) begin
		pair_t exp_pair;
		if (!arst_n) begin
			step_reg   = ONE_PHASE[STEP_W-1:0];
			mono_reg   = 1'b0;
			phase      = '0;
			prev_l     = '0;
			prev_r     = '0;
			primed     = 1'b0;
			pairs_due.delete();
			mismatches = 0;
			pairs_left <= 0;
		end else begin
			// a changed value restarts the history, an equal one is a no-op
			if (cfg_we) begin
				case (cfg_index)
					REG_STEP_SIZE: begin
						if (cfg_data[STEP_W-1:0] != step_reg) begin
							step_reg = cfg_data[STEP_W-1:0];
							phase    = '0;
							primed   = 1'b0;
						end
					end
					REG_MONO_SOURCE: begin
						if (cfg_data[0] != mono_reg) begin
							mono_reg = cfg_data[0];
							phase    = '0;
							primed   = 1'b0;
						end
					end
					default: ;
				endcase
			end

			if (in_valid && in_ready)
				predict_frame(left_in, right_in);

			// output transaction
			if (out_valid && out_ready) begin
				if (pairs_due.size() == 0) begin
					$error("pair with none due: left_out %0d right_out %0d run_last %0b",
						left_out, right_out, run_last);
					mismatches++;
				end else begin
					exp_pair = pairs_due.pop_front();
					if (left_out !== exp_pair.l_smp) begin
						$error("left_out: expected %0d, actual %0d", exp_pair.l_smp, left_out);
						mismatches++;
					end
					if (right_out !== exp_pair.r_smp) begin
						$error("right_out: expected %0d, actual %0d", exp_pair.r_smp, right_out);
						mismatches++;
					end
					if (run_last !== exp_pair.last) begin
						$error("run_last: expected %0b, actual %0b", exp_pair.last, run_last);
						mismatches++;
					end
				end
			end
			pairs_left <= pairs_due.size();
		end
	end

endmodule

// ===== tb/sv/tb_linear_resampler_stereo.sv =====
// ----------------------------------------------------------------------------
// tb_linear_resampler_stereo
// Drives source frames and register writes into the stereo resampler and
// gives the verdict. A directed opening covers sample extremes, the step
// extremes, zero step, mono, equal-value and spare-index writes; then random
// phases run under random step and mode settings with bursty frames, output
// stalls, one long output hold-off and one full drain mid-phase. Checking is
// done by lrs_pair_checker beside the block.
// ----------------------------------------------------------------------------
module tb_linear_resampler_stereo;
	import lrs_pkg::*;

	localparam int FRAC_BITS     = 32;
	localparam int CLK_PERIOD    = 4;
	localparam int RESET_CYCLES  = 6;
	localparam int HOLD_CYCLES   = 300;
	localparam int SETTLE_CYCLES = 20;
	localparam int STALL_LIMIT   = 2000;
	localparam int PHASES        = 10;
	localparam int PHASE_FRAMES  = 40;
	localparam int HOLD_PHASE    = 3;
	localparam int DRAIN_PHASE   = 6;

	// step settings: 8 kHz, 96 kHz, unity, zero and all ones
	localparam logic [STEP_W-1:0] STEP_LOW   = 34'd715827882;
	localparam logic [STEP_W-1:0] STEP_HIGH  = 34'h2_0000_0000;
	localparam logic [STEP_W-1:0] STEP_UNITY = 34'h1_0000_0000;
	localparam logic [STEP_W-1:0] STEP_ZERO  = '0;
	localparam logic [STEP_W-1:0] STEP_ALL   = '1;

	// indexes with no register behind them
	localparam logic [CFG_IDX_W-1:0] REG_SPARE_A = 2'd2;
	localparam logic [CFG_IDX_W-1:0] REG_SPARE_B = 2'd3;

	logic                       clk       = 1'b0;
	logic                       arst_n    = 1'b0;
	logic                       cfg_we    = 1'b0;
	logic [CFG_IDX_W-1:0]       cfg_index = REG_STEP_SIZE;
	logic [CFG_W-1:0]           cfg_data  = '0;
	logic                       in_valid  = 1'b0;
	logic                       in_ready;
	logic signed [SAMPLE_W-1:0] left_in   = '0;
	logic signed [SAMPLE_W-1:0] right_in  = '0;
	logic                       out_valid;
	logic                       out_ready = 1'b0;
	logic signed [SAMPLE_W-1:0] left_out;
	logic signed [SAMPLE_W-1:0] right_out;
	logic                       run_last;

	int mismatches;
	int pairs_left;

	// sender and receiver bookkeeping
	int burst_left   = 0;
	bit steady       = 1'b0;
	int holds_asked  = 0;
	int holds_served = 0;

	linear_resampler_stereo #(.FRAC_BITS(FRAC_BITS)) uut (.*);

	lrs_pair_checker #(.FRAC_BITS(FRAC_BITS)) pair_chk (.*);

	always #(CLK_PERIOD/2) clk = ~clk;

	// watchdog on cycles without any transaction
	initial begin : watchdog
		int idle;
		idle = 0;
		while (idle < STALL_LIMIT) begin
			@(posedge clk);
			if ((in_valid && in_ready) || (out_valid && out_ready) || cfg_we)
				idle = 0;
			else
				idle++;
		end
		$display("linear_resampler_stereo: mismatch");
		$finish;
	end

	// receiver stall patterns, with a long hold-off on request
	initial begin : receiver
		int mode;
		int span;
		forever begin
			mode = $urandom_range(3, 0);
			span = $urandom_range(60, 10);
			for (int k = 0; k < span; k++) begin
				@(posedge clk);
				if (holds_served != holds_asked) begin
					out_ready <= 1'b0;
					repeat (HOLD_CYCLES) @(posedge clk);
					holds_served++;
				end
				case (mode)
					0: out_ready <= 1'b1;
					1: out_ready <= $urandom_range(1, 0);
					2: out_ready <= ($urandom_range(3, 0) == 0);
					default: out_ready <= (k % 3 != 0);
				endcase
			end
		end
	end

	// offer one frame, opening a new burst after a random gap when due
	task automatic offer_frame(
		input logic signed [SAMPLE_W-1:0] l_smp,
		input logic signed [SAMPLE_W-1:0] r_smp
	);
		if (burst_left == 0) begin
			burst_left = $urandom_range(16, 1);
			if (!steady && $urandom_range(3, 0) != 0) begin
				in_valid <= 1'b0;
				repeat ($urandom_range(8, 1)) @(posedge clk);
			end
		end
		burst_left--;
		in_valid <= 1'b1;
		left_in  <= l_smp;
		right_in <= r_smp;
		do @(posedge clk); while (!in_ready);
	endtask

	// stop sending and wait until every pair due has come out
	task automatic drain_results();
		in_valid <= 1'b0;
		@(posedge clk);
		while (pairs_left != 0) @(posedge clk);
		// a frame with no pairs may still be in flight
		repeat (SETTLE_CYCLES) @(posedge clk);
	endtask

	task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_W-1:0] val);
		cfg_we    <= 1'b1;
		cfg_index <= idx;
		cfg_data  <= val;
		@(posedge clk);
	endtask

	// new step and mode once idle; mono data carries junk above bit 0
	task automatic set_mode(input logic [STEP_W-1:0] step, input logic mono, input logic spare);
		logic [CFG_W-1:0] junk;
		drain_results();
		junk    = CFG_W'({$urandom(), $urandom()});
		junk[0] = mono;
		write_reg(REG_STEP_SIZE, step);
		write_reg(REG_MONO_SOURCE, junk);
		if (spare)
			write_reg($urandom_range(1, 0) ? REG_SPARE_A : REG_SPARE_B,
				CFG_W'({$urandom(), $urandom()}));
		cfg_we <= 1'b0;
	endtask

	function automatic logic [STEP_W-1:0] rand_step();
		logic [63:0] r;
		r = {$urandom(), $urandom()};
		case ($urandom_range(9, 0))
			0: return STEP_ZERO;
			1: return STEP_LOW;
			2: return STEP_HIGH;
			3: return STEP_ALL;
			4: return STEP_W'(r);
			default: return STEP_W'(STEP_LOW + r % (STEP_HIGH - STEP_LOW + 1));
		endcase
	endfunction

	// full-scale noise, rails, or a small move from the last sample
	function automatic logic signed [SAMPLE_W-1:0] rand_sample(
		input logic signed [SAMPLE_W-1:0] near
	);
		case ($urandom_range(7, 0))
			0: return SAT_MAX;
			1: return SAT_MIN;
			2, 3: return SAMPLE_W'(near + $urandom_range(64, 0) - 32);
			default: return SAMPLE_W'($urandom());
		endcase
	endfunction

	initial begin : stimulus
		logic signed [SAMPLE_W-1:0] l_smp;
		logic signed [SAMPLE_W-1:0] r_smp;
		repeat (RESET_CYCLES) @(posedge clk);
		arst_n <= 1'b1;

		// reset setting: unity step, stereo; first frame only primes
		offer_frame('0, '0);
		offer_frame(SAT_MAX, SAT_MIN);
		offer_frame(SAT_MIN, SAT_MAX);
		offer_frame(-16'sd1, 16'sd1);
		offer_frame(16'sh5555, -16'sh5556);

		// lowest rate: six or seven pairs per frame across the rails
		set_mode(STEP_LOW, 1'b0, 1'b0);
		offer_frame(SAT_MIN, SAT_MAX);
		offer_frame(SAT_MAX, SAT_MIN);
		offer_frame('0, -16'sd1);

		// zero step: capped at seven pairs, rest of the interval dropped
		set_mode(STEP_ZERO, 1'b0, 1'b0);
		offer_frame(SAT_MAX, SAT_MIN);
		offer_frame(SAT_MIN, SAT_MAX);

		// highest rate in mono: every other frame emits nothing, right ignored
		set_mode(STEP_HIGH, 1'b1, 1'b0);
		offer_frame(16'sd100, -16'sd5);
		offer_frame(SAT_MAX, 16'sd7);
		offer_frame(SAT_MIN, 16'sd9);
		offer_frame(-16'sd1, 16'sd3);

		// all-ones step: phase well beyond the interval
		set_mode(STEP_ALL, 1'b0, 1'b0);
		offer_frame(16'sh1234, -16'sh1234);
		offer_frame(SAT_MIN, SAT_MAX);
		offer_frame(SAT_MAX, SAT_MAX);
		offer_frame(SAT_MIN, SAT_MIN);

		// equal values and a spare index keep the history
		set_mode(STEP_ALL, 1'b0, 1'b1);
		offer_frame(16'sd77, -16'sd77);
		offer_frame(SAT_MAX, SAT_MIN);

		// random phases under random settings
		l_smp = '0;
		r_smp = '0;
		for (int ph = 0; ph < PHASES; ph++) begin
			if (ph == HOLD_PHASE) begin
				set_mode(STEP_LOW, $urandom_range(1, 0), 1'b0);
				holds_asked++;
				steady = 1'b1;
			end else if (ph == PHASES - 1) begin
				set_mode(STEP_UNITY, $urandom_range(1, 0), 1'b1);
			end else begin
				set_mode(rand_step(), $urandom_range(1, 0), $urandom_range(3, 0) == 0);
			end
			for (int k = 0; k < PHASE_FRAMES; k++) begin
				if (ph == DRAIN_PHASE && k == PHASE_FRAMES / 2)
					drain_results();
				l_smp = rand_sample(l_smp);
				r_smp = rand_sample(r_smp);
				offer_frame(l_smp, r_smp);
			end
			steady = 1'b0;
		end

		drain_results();
		if (mismatches == 0 && pairs_left == 0)
			$display("linear_resampler_stereo: match");
		else
			$display("linear_resampler_stereo: mismatch");
		$finish;
	end

endmodule
